[rtl/bracket_balance_checker_unit_macros.svh]
// assertion helpers for the checker file
`ifndef BRACKET_BALANCE_CHECKER_UNIT_MACROS_SVH
`define BRACKET_BALANCE_CHECKER_UNIT_MACROS_SVH

// same-cycle implication, quiet during reset
`define BBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define BBC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bbc_pkg.sv]
package bbc_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int LINE_W          = 16;
  localparam int DEPTH_W         = 7;
  localparam int OUT_W           = 32;

  localparam logic [LINE_W-1:0] LINE_MAX = 16'hFFFF;
  localparam logic [LINE_W-1:0] LINE_ONE = 16'd1;

  localparam logic [7:0] CH_PAREN_OPEN   = 8'h28;
  localparam logic [7:0] CH_PAREN_CLOSE  = 8'h29;
  localparam logic [7:0] CH_SQUARE_OPEN  = 8'h5B;
  localparam logic [7:0] CH_SQUARE_CLOSE = 8'h5D;
  localparam logic [7:0] CH_CURLY_OPEN   = 8'h7B;
  localparam logic [7:0] CH_CURLY_CLOSE  = 8'h7D;
  localparam logic [7:0] CH_NEWLINE      = 8'h0A;

  typedef enum logic [2:0] {
    ST_FINE     = 3'd0,
    ST_EXTRA    = 3'd1,
    ST_WRONG    = 3'd2,
    ST_UNCLOSED = 3'd3,
    ST_GOOD     = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_PAREN  = 2'd1,
    KIND_SQUARE = 2'd2,
    KIND_CURLY  = 2'd3
  } kind_t;

  // classified byte handed from front to back
  typedef struct packed {
    kind_t opener;
    kind_t closer;
    logic  newline;
    logic  last;
  } class_t;

  function automatic class_t classify(input logic [7:0] b, input logic last);
    class_t c;
    c.opener  = KIND_NONE;
    c.closer  = KIND_NONE;
    c.newline = (b == CH_NEWLINE);
    c.last    = last;
    case (b)
      CH_PAREN_OPEN:   c.opener = KIND_PAREN;
      CH_SQUARE_OPEN:  c.opener = KIND_SQUARE;
      CH_CURLY_OPEN:   c.opener = KIND_CURLY;
      CH_PAREN_CLOSE:  c.closer = KIND_PAREN;
      CH_SQUARE_CLOSE: c.closer = KIND_SQUARE;
      CH_CURLY_CLOSE:  c.closer = KIND_CURLY;
      default:         c.opener = KIND_NONE;
    endcase
    return c;
  endfunction

endpackage

[rtl/bbc_front.sv]
module bbc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,   // [7:0] text_byte
  input  logic            in_tlast,   // end_of_text
  output logic            q_valid,
  output bbc_pkg::class_t q_word,
  input  logic            q_ready
);

  // two-entry queue of classified words
  bbc_pkg::class_t q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_tready = (cnt_r != 2'd2);
  assign q_valid   = (cnt_r != 2'd0);
  assign q_word    = q_mem_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= bbc_pkg::classify(in_tdata, in_tlast);
    end
  end

endmodule

[rtl/bbc_stack.sv]
module bbc_stack #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(STACK_DEPTH)-1:0] waddr,
  input  logic [1:0]                     wdata,
  input  logic [$clog2(STACK_DEPTH)-1:0] raddr,
  output logic [1:0]                     rdata
);

  logic [1:0] mem [STACK_DEPTH];
  logic [1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

[rtl/bbc_back.sv]
module bbc_back #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  bbc_pkg::class_t           q_word,
  output logic                      q_ready,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [bbc_pkg::OUT_W-1:0] out_tdata
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = $clog2(STACK_DEPTH);

  logic [CW-1:0]              count_r, count_nxt, count_after;
  logic [bbc_pkg::LINE_W-1:0] line_r, line_nxt;
  bbc_pkg::status_t           lerr_r, lerr_nxt, err_now, status;
  bbc_pkg::kind_t             lop_r, lop_nxt, op_now, kind;
  bbc_pkg::kind_t             top_r, top_nxt, top_after, below;
  logic                       ov_r, ov_nxt;
  logic [bbc_pkg::OUT_W-1:0]  data_r, data_nxt;
  logic                       fire, push, pop, full, empty;
  logic [1:0]                 st_rdata;
  logic [IW-1:0]              st_raddr;

  // top of stack lives in top_r; the entry below it is prefetched every cycle
  bbc_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (fire && push),
    .waddr (count_r[IW-1:0]),
    .wdata (q_word.opener),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  assign below      = bbc_pkg::kind_t'(st_rdata);
  assign q_ready    = !ov_r || out_tready;
  assign fire       = q_valid && q_ready;
  assign out_tvalid = ov_r;
  assign out_tdata  = data_r;
  assign full       = (count_r == CW'(STACK_DEPTH));
  assign empty      = (count_r == '0);

  always_comb begin
    push    = 1'b0;
    pop     = 1'b0;
    err_now = lerr_r;
    op_now  = lop_r;
    if (lerr_r == bbc_pkg::ST_FINE) begin
      if (q_word.opener != bbc_pkg::KIND_NONE) begin
        if (full) begin
          err_now = bbc_pkg::ST_OVERFLOW;
          op_now  = q_word.opener;
        end else begin
          push = 1'b1;
        end
      end else if (q_word.closer != bbc_pkg::KIND_NONE) begin
        if (empty) begin
          err_now = bbc_pkg::ST_EXTRA;
          op_now  = bbc_pkg::KIND_NONE;
        end else if (top_r != q_word.closer) begin
          err_now = bbc_pkg::ST_WRONG;
          op_now  = top_r;
        end else begin
          pop = 1'b1;
        end
      end
    end

    if (push) begin
      count_after = count_r + CW'(1);
      top_after   = q_word.opener;
    end else if (pop) begin
      count_after = count_r - CW'(1);
      top_after   = below;
    end else begin
      count_after = count_r;
      top_after   = top_r;
    end

    if (err_now != bbc_pkg::ST_FINE) begin
      status = err_now;
      kind   = op_now;
    end else if (q_word.last) begin
      if (count_after != '0) begin
        status = bbc_pkg::ST_UNCLOSED;
        kind   = top_after;
      end else begin
        status = bbc_pkg::ST_GOOD;
        kind   = bbc_pkg::KIND_NONE;
      end
    end else begin
      status = bbc_pkg::ST_FINE;
      kind   = bbc_pkg::KIND_NONE;
    end
  end

  always_comb begin
    count_nxt = count_r;
    line_nxt  = line_r;
    lerr_nxt  = lerr_r;
    lop_nxt   = lop_r;
    top_nxt   = top_r;
    data_nxt  = data_r;
    ov_nxt    = ov_r && !out_tready;
    if (fire) begin
      ov_nxt   = 1'b1;
      data_nxt = {{(bbc_pkg::OUT_W - 28){1'b0}}, 7'(count_after), kind, line_r, status};
      if (q_word.last) begin
        count_nxt = '0;
        line_nxt  = bbc_pkg::LINE_ONE;
        lerr_nxt  = bbc_pkg::ST_FINE;
        lop_nxt   = bbc_pkg::KIND_NONE;
        top_nxt   = top_after;
      end else begin
        count_nxt = count_after;
        lerr_nxt  = err_now;
        lop_nxt   = op_now;
        top_nxt   = top_after;
        // newline only counts while no error is latched
        if (status == bbc_pkg::ST_FINE && q_word.newline && line_r != bbc_pkg::LINE_MAX) begin
          line_nxt = line_r + bbc_pkg::LINE_ONE;
        end
      end
    end
    st_raddr = IW'(count_nxt - CW'(2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      line_r  <= bbc_pkg::LINE_ONE;
      lerr_r  <= bbc_pkg::ST_FINE;
      lop_r   <= bbc_pkg::KIND_NONE;
      ov_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      line_r  <= line_nxt;
      lerr_r  <= lerr_nxt;
      lop_r   <= lop_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r  <= top_nxt;
    data_r <= data_nxt;
  end

endmodule

[rtl/bracket_balance_checker_unit.sv]
// Balanced-bracket checker over a byte stream. Each input word carries one text
// byte, with tlast marking the end of a text; every accepted word produces
// exactly one result word giving status, line number, offending opener and
// nesting depth. The unit sustains one word per clock while the output is not
// stalled. A result word passes through a front queue entry and then the
// output register before it is valid on the output. The rate is set by the
// stack: its top sits in a flop and the entry below it is read ahead from a
// single-port-read stack memory every cycle, so a push or pop per cycle never
// waits. The stack memory is not cleared after reset; only entries below the
// current depth are ever used.
// The first error freezes line and depth until the end word, which gives the
// verdict and returns the unit to its reset state.
module bracket_balance_checker_unit #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [7:0] text_byte
  input  logic                      in_tlast,   // end_of_text
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // [2:0] status, [18:3] line_number, [20:19] opener_kind,
  // [27:21] nesting_depth, [31:28] zero
  output logic [bbc_pkg::OUT_W-1:0] out_tdata
);

  logic            q_valid, q_ready;
  bbc_pkg::class_t q_word;

  bbc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_ready   (q_ready)
  );

  bbc_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_word     (q_word),
    .q_ready    (q_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[rtl/bbc_checker.sv]
`include "bracket_balance_checker_unit_macros.svh"

module bbc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [bbc_pkg::OUT_W-1:0] out_tdata
);

  logic [2:0] st;
  logic [1:0] kd;
  logic       in_word;

  assign st      = out_tdata[2:0];
  assign kd      = out_tdata[20:19];
  assign in_word = in_tvalid && in_tready;

  `BBC_ASSERT_IMP(a_status_code, out_tvalid, st <= bbc_pkg::ST_OVERFLOW, "bad status code")
  `BBC_ASSERT_IMP(a_no_kind_when_ok,
    out_tvalid && (st == bbc_pkg::ST_FINE || st == bbc_pkg::ST_GOOD || st == bbc_pkg::ST_EXTRA),
    kd == bbc_pkg::KIND_NONE, "opener named without a matching error")
  `BBC_ASSERT_IMP(a_line_nonzero, out_tvalid, out_tdata[18:3] != 16'd0, "line number zero")
  `BBC_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata), "stalled result changed")
  // an accepted word must be answered by a valid result on the output
  `BBC_ASSERT_IMP(a_result_follows, in_word, ##2 out_tvalid, "accepted word gave no result")

endmodule

bind bracket_balance_checker_unit bbc_checker u_bbc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
